// ----- sv/pph_pkg.sv -----
package pph_pkg;

    localparam int FRAC_BITS  = 32;
    localparam int VAL_W      = 64;
    localparam int ADDR_W     = 6;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 4;

    // scratch memory map
    localparam int A_K   = 0;
    localparam int A_H   = 9;
    localparam int A_ADJ = 18;
    localparam int A_G   = 27;
    localparam int A_CRS = 36;
    localparam int A_DET = 39;
    localparam int A_NRM = 40;

    typedef enum logic [3:0] {
        OP_MUL_LD,
        OP_MUL_ADD,
        OP_MUL_SUB,
        OP_SQ0,
        OP_SQ,
        OP_DIV,
        OP_SQRT,
        OP_CHK_DET,
        OP_CHK_SUM,
        OP_EMIT,
        OP_END
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SINGULAR = 2'd1,
        ST_ZERO_COL = 2'd2
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] ra;
        logic [ADDR_W-1:0] rb;
        logic [ADDR_W-1:0] wa;
        logic              wr;
        logic              neg;
        logic              sol;
        logic              part;
        logic [1:0]        row;
        logic [1:0]        col;
        logic              last;
    } t_uop;

    localparam int PROG_LEN = 103;
    localparam int PC_W     = $clog2(PROG_LEN);

    typedef t_uop [PROG_LEN-1:0] t_prog;

    typedef struct packed {
        logic    ld;
        logic    rd;
        logic    go;
        logic    wb;
        logic    emit;
        logic    stat;
        t_status code;
        t_uop    uop;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic acc_zero;
        logic sum_zero;
        logic out_free;
    } t_sts;

    function automatic int nx(int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

    function automatic t_uop mk(t_op op, int ra, int rb, int wa, logic wr);
        t_uop u;
        u      = '0;
        u.op   = op;
        u.ra   = ADDR_W'(ra);
        u.rb   = ADDR_W'(rb);
        u.wa   = ADDR_W'(wa);
        u.wr   = wr;
        return u;
    endfunction

    function automatic t_prog build_prog();
        t_prog p;
        int    n;
        int    i1;
        int    i2;
        int    j1;
        int    j2;
        int    a;
        int    b;
        p = '0;
        n = 0;
        // adjugate of the camera matrix
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                j1 = nx(j);
                j2 = nx(j1);
                i1 = nx(i);
                i2 = nx(i1);
                p[n] = mk(OP_MUL_LD, A_K + j1 * 3 + i1, A_K + j2 * 3 + i2, 0, 1'b0);
                n++;
                p[n] = mk(OP_MUL_SUB, A_K + j1 * 3 + i2, A_K + j2 * 3 + i1,
                          A_ADJ + i * 3 + j, 1'b1);
                n++;
            end
        end
        // determinant
        p[n] = mk(OP_MUL_LD, A_K + 0, A_ADJ + 0, 0, 1'b0);
        n++;
        p[n] = mk(OP_MUL_ADD, A_K + 1, A_ADJ + 3, 0, 1'b0);
        n++;
        p[n] = mk(OP_MUL_ADD, A_K + 2, A_ADJ + 6, A_DET, 1'b1);
        n++;
        p[n] = mk(OP_CHK_DET, 0, 0, 0, 1'b0);
        n++;
        // inverse in place
        for (int i = 0; i < 9; i++) begin
            p[n] = mk(OP_DIV, A_ADJ + i, A_DET, A_ADJ + i, 1'b1);
            n++;
        end
        // g = inverse times homography
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p[n] = mk(OP_MUL_LD, A_ADJ + i * 3, A_H + j, 0, 1'b0);
                n++;
                p[n] = mk(OP_MUL_ADD, A_ADJ + i * 3 + 1, A_H + 3 + j, 0, 1'b0);
                n++;
                p[n] = mk(OP_MUL_ADD, A_ADJ + i * 3 + 2, A_H + 6 + j, A_G + i * 3 + j, 1'b1);
                n++;
            end
        end
        // norm of the first column, and G divided by it
        p[n] = mk(OP_SQ0, A_G + 0, A_G + 0, 0, 1'b0);
        n++;
        p[n] = mk(OP_SQ, A_G + 3, A_G + 3, 0, 1'b0);
        n++;
        p[n] = mk(OP_SQ, A_G + 6, A_G + 6, 0, 1'b0);
        n++;
        p[n] = mk(OP_CHK_SUM, 0, 0, 0, 1'b0);
        n++;
        p[n] = mk(OP_SQRT, 0, 0, A_NRM, 1'b1);
        n++;
        for (int i = 0; i < 9; i++) begin
            p[n] = mk(OP_DIV, A_G + i, A_NRM, A_G + i, 1'b1);
            n++;
        end
        // third rotation column
        for (int i = 0; i < 3; i++) begin
            a = nx(i);
            b = nx(a);
            p[n] = mk(OP_MUL_LD, A_G + a * 3, A_G + b * 3 + 1, 0, 1'b0);
            n++;
            p[n] = mk(OP_MUL_SUB, A_G + b * 3, A_G + a * 3 + 1, A_CRS + i, 1'b1);
            n++;
        end
        // results
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    p[n]     = mk(OP_EMIT, (j == 2) ? A_CRS + i : A_G + i * 3 + j, 0, 0, 1'b0);
                    p[n].neg = (k == 1) && (j != 2);
                    p[n].sol = 1'(k);
                    p[n].row = 2'(i);
                    p[n].col = 2'(j);
                    n++;
                end
            end
            for (int i = 0; i < 3; i++) begin
                p[n]      = mk(OP_EMIT, A_G + i * 3 + 2, 0, 0, 1'b0);
                p[n].neg  = (k == 1);
                p[n].sol  = 1'(k);
                p[n].part = 1'b1;
                p[n].row  = 2'(i);
                p[n].last = (k == 1) && (i == 2);
                n++;
            end
        end
        p[n] = mk(OP_END, 0, 0, 0, 1'b0);
        return p;
    endfunction

    localparam t_prog PROG = build_prog();

endpackage

// ----- sv/pph_ctrl.sv -----
module pph_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    output logic          o_s_tready,
    input  pph_pkg::t_sts i_sts,
    output pph_pkg::t_cmd o_cmd
);
    import pph_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_GO,
        S_WAIT,
        S_STAT
    } t_state;

    t_state           r_state, n_state;
    logic [PC_W-1:0]  r_pc, n_pc;
    t_status          r_code, n_code;
    t_uop             uop;

    assign uop = PROG[r_pc];

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_code     = r_code;
        o_cmd      = '0;
        o_cmd.uop  = uop;
        o_cmd.code = r_code;
        o_s_tready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.ld = 1'b1;
                    if (i_s_tlast) begin
                        n_pc    = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_GO;
            end
            S_GO: begin
                case (uop.op) inside
                    OP_MUL_LD, OP_MUL_ADD, OP_MUL_SUB, OP_SQ0, OP_SQ, OP_DIV, OP_SQRT: begin
                        o_cmd.go = 1'b1;
                        n_state  = S_WAIT;
                    end
                    OP_CHK_DET: begin
                        if (i_sts.acc_zero) begin
                            n_code  = ST_SINGULAR;
                            n_state = S_STAT;
                        end else begin
                            n_pc    = PC_W'(r_pc + 1'b1);
                            n_state = S_READ;
                        end
                    end
                    OP_CHK_SUM: begin
                        if (i_sts.sum_zero) begin
                            n_code  = ST_ZERO_COL;
                            n_state = S_STAT;
                        end else begin
                            n_pc    = PC_W'(r_pc + 1'b1);
                            n_state = S_READ;
                        end
                    end
                    OP_EMIT: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit = 1'b1;
                            n_pc       = PC_W'(r_pc + 1'b1);
                            n_state    = S_READ;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_WAIT: begin
                if (i_sts.done) begin
                    o_cmd.wb = uop.wr;
                    n_pc     = PC_W'(r_pc + 1'b1);
                    n_state  = S_READ;
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.stat = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_code  <= n_code;
        end
    end

endmodule

// ----- sv/pph_datapath.sv -----
module pph_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pph_pkg::t_cmd                      i_cmd,
    output pph_pkg::t_sts                      o_sts,
    input  logic [pph_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic                               i_in_sel,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [pph_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic [pph_pkg::OUT_USER_W-1:0]     o_m_tuser,
    output logic                               o_m_tlast
);
    import pph_pkg::*;

    localparam int DN     = VAL_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DN + 1);
    localparam int PAD_W  = OUT_DATA_W - VAL_W - 4;
    localparam logic [VAL_W-1:0] MAXV    = {1'b0, {(VAL_W - 1){1'b1}}};
    localparam logic [VAL_W-1:0] MINV    = {1'b1, {(VAL_W - 1){1'b0}}};
    localparam logic [127:0]     NEG_LIM = 128'(1) << (VAL_W - 1);
    localparam logic [127:0]     POS_LIM = 128'(MAXV);
    localparam logic [127:0]     HALF    = 128'(1) << (FRAC_BITS - 1);

    typedef enum logic [3:0] {
        P_IDLE, P_MUL, P_MRND, P_MACC, P_DIV, P_DRUP, P_DINC, P_DSAT, P_SQRT, P_SRUP, P_SSAT
    } t_ph;

    function automatic logic [VAL_W-1:0] mag(logic [VAL_W-1:0] a);
        return a[VAL_W-1] ? VAL_W'(-a) : a;
    endfunction

    function automatic logic [VAL_W-1:0] from_mag(logic neg, logic [127:0] m);
        logic [VAL_W-1:0] r;
        if (neg) r = (m > NEG_LIM) ? MINV : VAL_W'(-m[VAL_W-1:0]);
        else     r = (m > POS_LIM) ? MAXV : m[VAL_W-1:0];
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] sat_fix(logic [VAL_W:0] s);
        logic [VAL_W-1:0] r;
        if (s[VAL_W] != s[VAL_W-1]) r = s[VAL_W] ? MINV : MAXV;
        else                        r = s[VAL_W-1:0];
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] sat_neg(logic [VAL_W-1:0] a);
        return (a == MINV) ? MAXV : VAL_W'(-a);
    endfunction

    // scratch memory
    logic [VAL_W-1:0]     r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_vld;
    logic [VAL_W-1:0]     r_rda, r_rdb;
    logic                 r_va, r_vb;
    logic [VAL_W-1:0]     opa, opb;

    logic [1:0]           in_row, in_col;
    logic [VAL_W-1:0]     in_val;
    logic                 in_ok;
    logic [3:0]           ld_idx;
    logic [ADDR_W-1:0]    ld_addr;
    logic                 w_en;
    logic [ADDR_W-1:0]    w_addr;
    logic [VAL_W-1:0]     w_data;

    // unit state
    t_ph                  r_ph;
    t_op                  r_op;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_done, n_done;
    logic [VAL_W-1:0]     r_res, r_acc, r_mres;
    logic [VAL_W-1:0]     r_ma, r_mb;
    logic                 r_mneg;
    logic [63:0]          r_pp;
    logic [1:0]           r_ppk;
    logic [127:0]         r_prod, r_sumsq;
    logic [VAL_W-1:0]     r_dub, r_drem;
    logic [DN-1:0]        r_dnum, r_dq;
    logic                 r_dneg, r_drup;
    logic [127:0]         r_dqr;
    logic [127:0]         r_ss;
    logic [65:0]          r_srem;
    logic [VAL_W-1:0]     r_sroot;
    logic                 r_srup;

    logic                 r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic [OUT_USER_W-1:0] r_ouser;
    logic                 r_olast;

    // combinational helpers
    logic [31:0]          pa, pb;
    logic [127:0]         m_rnd;
    logic [VAL_W-1:0]     m_val, m_comb;
    logic [VAL_W:0]       d_sh;
    logic                 d_ge;
    logic [67:0]          s_sh, s_trial;
    logic                 s_ge;
    logic [VAL_W:0]       s_r65;
    logic [VAL_W-1:0]     e_val;

    assign in_row  = i_in_data[1:0];
    assign in_col  = i_in_data[3:2];
    assign in_val  = i_in_data[VAL_W+3:4];
    assign in_ok   = (in_row != 2'd3) && (in_col != 2'd3);
    assign ld_idx  = 4'({in_row, 1'b0}) + 4'(in_row) + 4'(in_col);
    assign ld_addr = i_in_sel ? ADDR_W'(A_H) + ADDR_W'(ld_idx) : ADDR_W'(ld_idx);
    assign w_en    = (i_cmd.ld && in_ok) || i_cmd.wb;
    assign w_addr  = i_cmd.ld ? ld_addr : i_cmd.uop.wa;
    assign w_data  = i_cmd.ld ? in_val : r_res;

    assign opa = r_va ? r_rda : '0;
    assign opb = r_vb ? r_rdb : '0;

    always_ff @(posedge i_clk) begin
        if (w_en) r_mem[w_addr] <= w_data;
        if (i_cmd.rd) begin
            r_rda <= r_mem[i_cmd.uop.ra];
            r_rdb <= r_mem[i_cmd.uop.rb];
            r_va  <= r_vld[i_cmd.uop.ra];
            r_vb  <= r_vld[i_cmd.uop.rb];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_vld <= '0;
        else if (w_en) r_vld[w_addr] <= 1'b1;
    end

    always_comb begin
        pa      = r_cnt[0] ? r_ma[63:32] : r_ma[31:0];
        pb      = r_cnt[1] ? r_mb[63:32] : r_mb[31:0];
        m_rnd   = (r_prod + HALF) >> FRAC_BITS;
        m_val   = from_mag(r_mneg, m_rnd);
        case (r_op)
            OP_MUL_ADD: m_comb = sat_fix({r_acc[VAL_W-1], r_acc} + {r_mres[VAL_W-1], r_mres});
            OP_MUL_SUB: m_comb = sat_fix({r_acc[VAL_W-1], r_acc} - {r_mres[VAL_W-1], r_mres});
            default:    m_comb = r_mres;
        endcase
        d_sh    = {r_drem, r_dnum[DN-1]};
        d_ge    = d_sh >= {1'b0, r_dub};
        s_sh    = {r_srem, r_ss[127:126]};
        s_trial = {2'b00, r_sroot, 2'b01};
        s_ge    = s_sh >= s_trial;
        s_r65   = {1'b0, r_sroot} + (VAL_W + 1)'(r_srup);
        e_val   = i_cmd.uop.neg ? sat_neg(opa) : opa;
        n_done  = ((r_ph == P_MRND) && (r_op == OP_SQ0 || r_op == OP_SQ))
                  || (r_ph == P_MACC) || (r_ph == P_DSAT) || (r_ph == P_SSAT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph     <= P_IDLE;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_done <= n_done;
            if (i_cmd.emit || i_cmd.stat) r_ovalid <= 1'b1;
            else if (i_m_tready)          r_ovalid <= 1'b0;
            if (i_cmd.emit) begin
                r_odata  <= {{PAD_W{1'b0}}, e_val, i_cmd.uop.col, i_cmd.uop.row};
                r_ouser  <= {ST_OK, i_cmd.uop.part, i_cmd.uop.sol};
                r_olast  <= i_cmd.uop.last;
            end
            if (i_cmd.stat) begin
                r_odata  <= '0;
                r_ouser  <= {i_cmd.code, 2'b00};
                r_olast  <= 1'b1;
            end
            unique case (r_ph)
                P_IDLE: begin
                    if (i_cmd.go) begin
                        r_op  <= i_cmd.uop.op;
                        r_cnt <= '0;
                        case (i_cmd.uop.op)
                            OP_DIV: begin
                                r_dub  <= mag(opb);
                                r_dnum <= {mag(opa), {FRAC_BITS{1'b0}}};
                                r_drem <= '0;
                                r_dq   <= '0;
                                r_dneg <= opa[VAL_W-1] ^ opb[VAL_W-1];
                                r_ph   <= P_DIV;
                            end
                            OP_SQRT: begin
                                r_ss    <= r_sumsq;
                                r_srem  <= '0;
                                r_sroot <= '0;
                                r_ph    <= P_SQRT;
                            end
                            default: begin
                                r_ma   <= mag(opa);
                                r_mb   <= mag(opb);
                                r_mneg <= opa[VAL_W-1] ^ opb[VAL_W-1];
                                r_prod <= '0;
                                r_ph   <= P_MUL;
                            end
                        endcase
                    end
                end
                // four 32x32 partial products, each accumulated in the cycle after it is formed
                P_MUL: begin
                    r_pp  <= 64'(pa) * 64'(pb);
                    r_ppk <= 2'(r_cnt[0]) + 2'(r_cnt[1]);
                    if (r_cnt != '0) r_prod <= r_prod + (128'(r_pp) << {r_ppk, 5'b0});
                    r_cnt <= CNT_W'(r_cnt + 1'b1);
                    if (r_cnt == CNT_W'(4)) r_ph <= P_MRND;
                end
                P_MRND: begin
                    if (r_op == OP_SQ0 || r_op == OP_SQ) begin
                        r_sumsq <= ((r_op == OP_SQ0) ? 128'(0) : r_sumsq) + r_prod;
                        r_ph    <= P_IDLE;
                    end else begin
                        r_mres <= m_val;
                        r_ph   <= P_MACC;
                    end
                end
                P_MACC: begin
                    r_res  <= m_comb;
                    r_acc  <= m_comb;
                    r_ph   <= P_IDLE;
                end
                // restoring division, one quotient bit a cycle
                P_DIV: begin
                    r_drem <= d_ge ? VAL_W'(d_sh - {1'b0, r_dub}) : d_sh[VAL_W-1:0];
                    r_dnum <= {r_dnum[DN-2:0], 1'b0};
                    r_dq   <= {r_dq[DN-2:0], d_ge};
                    r_cnt  <= CNT_W'(r_cnt + 1'b1);
                    if (r_cnt == CNT_W'(DN - 1)) r_ph <= P_DRUP;
                end
                P_DRUP: begin
                    r_drup <= r_drem >= (r_dub - r_drem);
                    r_ph   <= P_DINC;
                end
                P_DINC: begin
                    r_dqr <= 128'(r_dq) + 128'(r_drup);
                    r_ph  <= P_DSAT;
                end
                P_DSAT: begin
                    r_res  <= from_mag(r_dneg, r_dqr);
                    r_ph   <= P_IDLE;
                end
                // digit-by-digit square root, one root bit a cycle
                P_SQRT: begin
                    r_srem  <= s_ge ? 66'(s_sh - s_trial) : s_sh[65:0];
                    r_sroot <= {r_sroot[VAL_W-2:0], s_ge};
                    r_ss    <= {r_ss[125:0], 2'b00};
                    r_cnt   <= CNT_W'(r_cnt + 1'b1);
                    if (r_cnt == CNT_W'(VAL_W - 1)) r_ph <= P_SRUP;
                end
                P_SRUP: begin
                    r_srup <= r_srem > {2'b00, r_sroot};
                    r_ph   <= P_SSAT;
                end
                P_SSAT: begin
                    r_res  <= (s_r65 > {1'b0, MAXV}) ? MAXV : s_r65[VAL_W-1:0];
                    r_ph   <= P_IDLE;
                end
                default: r_ph <= P_IDLE;
            endcase
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.acc_zero = (r_acc == '0);
    assign o_sts.sum_zero = (r_sumsq == '0);
    assign o_sts.out_free = !r_ovalid || i_m_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

endmodule

// ----- sv/planar_pose_from_homography.sv -----
// Planar pose from a plane-to-image homography in signed Q32.32. Elements of the camera
// matrix (tuser 0) and homography (tuser 1) load one per cycle; a transaction with tlast
// set stores its element and then starts the solve, during which no input is accepted.
// The solve runs a microcode sequencer over one shared multiplier (32x32 partial products),
// one radix-2 divider (18 quotients) and a bit-serial square root; with FRAC_BITS of 32 the
// divider dominates the run time of a burst, and any output stall adds to it. The result
// is 24 transactions (solution 0 rotation row major, its translation, then solution 1), or
// one status transaction when the camera matrix is singular or the first column of G is
// zero. A result may wait in the output register while new loads proceed.
module planar_pose_from_homography (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [pph_pkg::IN_DATA_W-1:0]      i_s_tdata,  // row[1:0], col[3:2], value[67:4]
    input  logic                               i_s_tuser,  // matrix_select
    input  logic                               i_s_tlast,  // start_compute
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [pph_pkg::OUT_DATA_W-1:0]     o_m_tdata,  // out_row[1:0], out_col[3:2], out_value[67:4]
    output logic [pph_pkg::OUT_USER_W-1:0]     o_m_tuser,  // solution[0], part[1], status[3:2]
    output logic                               o_m_tlast   // last
);
    import pph_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pph_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_data  (i_s_tdata),
        .i_in_sel   (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- sv/pph_checker.sv -----
module pph_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic [pph_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input logic                               i_s_tuser,
    input logic                               i_s_tlast,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [pph_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input logic [pph_pkg::OUT_USER_W-1:0]     o_m_tuser,
    input logic                               o_m_tlast
);
    import pph_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // the input is not ready right after a start transaction is accepted
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input accepted right after start");

    // status results are zero-payload, carry no solution or part flag, and are last
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[3:2] != ST_OK) |-> o_m_tlast && (o_m_tdata == '0)
            && (o_m_tuser[1:0] == 2'b00))
        else $error("bad status result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[3:2] == ST_OK) || (o_m_tuser[3:2] == ST_SINGULAR)
            || (o_m_tuser[3:2] == ST_ZERO_COL))
        else $error("undefined status code");

    // the final pose result is the last translation row of the negated solution
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast && (o_m_tuser[3:2] == ST_OK) |->
            (o_m_tuser[1:0] == 2'b11) && (o_m_tdata[1:0] == 2'd2) && (o_m_tdata[3:2] == 2'd0))
        else $error("last flag on wrong result");

endmodule

bind planar_pose_from_homography pph_checker u_pph_checker (.*);
